@@ design/dsf_pkg.sv @@
// Shared types, constants and helpers for the synthesizer serial command framer.
`default_nettype none

package dsf_pkg;

  typedef enum logic [1:0] {
    OP_FREQ     = 2'd0,
    OP_AMP      = 2'd1,
    OP_PHASE    = 2'd2,
    OP_FREQ_ALL = 2'd3
  } dsf_op_t;

  localparam logic [1:0] CFG_SELECT = 2'd0;
  localparam logic [1:0] CFG_FREQ   = 2'd1;
  localparam logic [1:0] CFG_AMP    = 2'd2;
  localparam logic [1:0] CFG_PHASE  = 2'd3;

  localparam logic [6:0] SELECT_ADDR_RESET = 7'd0;
  localparam logic [6:0] FREQ_ADDR_RESET   = 7'd4;
  localparam logic [6:0] AMP_ADDR_RESET    = 7'd6;
  localparam logic [6:0] PHASE_ADDR_RESET  = 7'd5;

  localparam logic [15:0] AMP_ENABLE  = 16'h1000;
  localparam logic [7:0]  SELECT_BASE = 8'h10;

  // The tuning word is hz * 2^32 / 500e6 = hz * 2^24 / 5^9. It is taken as
  // (hz * ceil(2^75 / 5^9)) >> 51, which is exact for every 29-bit hz.
  localparam int unsigned FTW_SHIFT = 51;
  localparam logic [75:0] FTW_RECIP_FULL =
    ((76'd1 << 75) + 76'd1953124) / 76'd1953125;
  localparam logic [54:0] FTW_RECIP    = FTW_RECIP_FULL[54:0];
  localparam logic [31:0] FTW_RECIP_LO = FTW_RECIP[31:0];
  localparam logic [22:0] FTW_RECIP_HI = FTW_RECIP[54:32];

  // Phase offset is floor((r + 720) / 1440) = floor(((r + 720) >> 5) / 45),
  // and the division by 45 is (m * ceil(2^26 / 45)) >> 26, exact for m < 2^20.
  localparam logic [24:0] PHASE_FULL  = 25'd23592960;
  localparam logic [24:0] PHASE_ROUND = 25'd720;
  localparam int unsigned PH_SHIFT = 26;
  localparam logic [26:0] PH_RECIP_FULL = ((27'd1 << 26) + 27'd44) / 27'd45;
  localparam logic [20:0] PH_RECIP = PH_RECIP_FULL[20:0];

  typedef struct packed {
    logic [6:0] select_addr;
    logic [6:0] freq_addr;
    logic [6:0] amp_addr;
    logic [6:0] phase_addr;
  } dsf_addr_t;

  typedef struct packed {
    dsf_op_t     op;
    logic [1:0]  channel;
    logic [31:0] value;
  } dsf_cmd_t;

  // Index of the final byte of one select-plus-value frame pair.
  function automatic logic [2:0] last_index(dsf_op_t op);
    logic [2:0] idx;
    case (op)
      OP_FREQ:     idx = 3'd6;
      OP_FREQ_ALL: idx = 3'd6;
      OP_AMP:      idx = 3'd5;
      OP_PHASE:    idx = 3'd4;
      default:     idx = 3'd6;
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

@@ design/dsf_cmd_if.sv @@
// Command request channel: op, channel and the three value fields.
`default_nettype none

interface dsf_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [2:0]         channel;
  logic [28:0]        frequency_hz;
  logic [15:0]        amplitude_word;
  logic signed [25:0] phase_deg_q16;

  modport source(output valid, op, channel, frequency_hz, amplitude_word, phase_deg_q16,
                 input ready);
  modport sink(input valid, op, channel, frequency_hz, amplitude_word, phase_deg_q16,
               output ready);
endinterface

`default_nettype wire

@@ design/dsf_byte_if.sv @@
// Serial byte channel: one byte per request with frame and command end marks.
`default_nettype none

interface dsf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] spi_byte;
  logic       frame_end;
  logic       last;

  modport source(output valid, spi_byte, frame_end, last, input ready);
  modport sink(input valid, spi_byte, frame_end, last, output ready);
endinterface

`default_nettype wire

@@ design/dsf_calc.sv @@
// Three-stage arithmetic pipeline that turns a command into a register value.
`default_nettype none

module dsf_calc
  import dsf_pkg::*;
#(
  parameter int NUM_CHANNELS = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  dsf_cmd_if.sink           cmd,
  output dsf_cmd_t          res,
  output logic              res_valid,
  input  wire logic         res_ready
);

  logic rdy1, rdy2, rdy3;

  // Stage 1: operand capture and phase clamp.
  logic        v1;
  dsf_op_t     op1;
  logic [1:0]  ch1;
  logic [28:0] hz1;
  logic [15:0] amp1;
  logic [19:0] m1;

  // Stage 2: products.
  logic        v2;
  dsf_op_t     op2;
  logic [1:0]  ch2;
  logic [15:0] amp2;
  logic [60:0] plo2;
  logic [51:0] phi2;
  logic [40:0] pm2;

  // Stage 3: finished value.
  logic        v3;
  dsf_cmd_t    r3;

  dsf_op_t     in_op;
  logic        in_keep;
  logic [24:0] ph_clamp;
  logic [24:0] ph_num;
  logic [83:0] ftw_sum;
  logic [31:0] value_next;

  assign rdy3 = !v3 || res_ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign cmd.ready = rdy1;

  assign in_op   = dsf_op_t'(cmd.op);
  assign in_keep = (in_op == OP_FREQ_ALL) || (cmd.channel < 3'(NUM_CHANNELS));

  always_comb begin
    if (cmd.phase_deg_q16[25]) begin
      ph_clamp = '0;
    end else if (cmd.phase_deg_q16[24:0] > PHASE_FULL) begin
      ph_clamp = PHASE_FULL;
    end else begin
      ph_clamp = cmd.phase_deg_q16[24:0];
    end
    ph_num = PHASE_FULL - ph_clamp + PHASE_ROUND;
  end

  assign ftw_sum = {phi2, 32'b0} + {23'b0, plo2};

  always_comb begin
    case (op2)
      OP_AMP:   value_next = {16'b0, amp2};
      OP_PHASE: value_next = {17'b0, pm2[40:PH_SHIFT]};
      default:  value_next = ftw_sum[FTW_SHIFT+31:FTW_SHIFT];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= cmd.valid && in_keep;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      op1  <= in_op;
      ch1  <= cmd.channel[1:0];
      hz1  <= cmd.frequency_hz;
      amp1 <= cmd.amplitude_word | AMP_ENABLE;
      m1   <= ph_num[24:5];
    end
    if (rdy2) begin
      op2  <= op1;
      ch2  <= ch1;
      amp2 <= amp1;
      plo2 <= 61'(hz1) * 61'(FTW_RECIP_LO);
      phi2 <= 52'(hz1) * 52'(FTW_RECIP_HI);
      pm2  <= 41'(m1) * 41'(PH_RECIP);
    end
    if (rdy3) begin
      r3.op      <= op2;
      r3.channel <= ch2;
      r3.value   <= value_next;
    end
  end

  assign res       = r3;
  assign res_valid = v3;

endmodule

`default_nettype wire

@@ design/dsf_serializer.sv @@
// Byte sequencer that emits the select and value frames of one command.
`default_nettype none

module dsf_serializer
  import dsf_pkg::*;
#(
  parameter int NUM_CHANNELS = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire dsf_addr_t    addr,
  input  wire dsf_cmd_t     req,
  input  wire logic         req_valid,
  output logic              req_ready,
  dsf_byte_if.source        spi
);

  logic        busy;
  dsf_cmd_t    cur;
  logic [2:0]  idx;
  logic [1:0]  ch_cur;

  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_frame_end;
  logic        out_last;

  logic        adv;
  logic [2:0]  lidx;
  logic [1:0]  bsel;
  logic        pair_end;
  logic        cmd_end;
  logic [1:0]  ch_sel;
  logic [6:0]  val_addr;
  logic [7:0]  byte_next;

  assign adv      = !out_valid || spi.ready;
  assign lidx     = last_index(cur.op);
  assign bsel     = 2'(lidx - idx);
  assign pair_end = (idx == lidx);
  assign cmd_end  = pair_end &&
                    ((cur.op != OP_FREQ_ALL) || (ch_cur == 2'(NUM_CHANNELS - 1)));
  assign ch_sel   = (cur.op == OP_FREQ_ALL) ? ch_cur : cur.channel;
  assign req_ready = !busy || (adv && cmd_end);

  always_comb begin
    case (cur.op)
      OP_AMP:   val_addr = addr.amp_addr;
      OP_PHASE: val_addr = addr.phase_addr;
      default:  val_addr = addr.freq_addr;
    endcase
  end

  always_comb begin
    case (idx)
      3'd0:    byte_next = {1'b0, addr.select_addr};
      3'd1:    byte_next = SELECT_BASE << ch_sel;
      3'd2:    byte_next = {1'b0, val_addr};
      default: byte_next = cur.value[{bsel, 3'b000} +: 8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
      ch_cur    <= '0;
    end else begin
      if (adv) begin
        out_valid <= busy;
      end
      if (req_ready) begin
        busy <= req_valid;
      end
      if (req_ready && req_valid) begin
        idx    <= '0;
        ch_cur <= '0;
      end else if (busy && adv) begin
        if (pair_end) begin
          idx    <= '0;
          ch_cur <= ch_cur + 2'd1;
        end else begin
          idx <= idx + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      cur <= req;
    end
    if (busy && adv) begin
      out_byte      <= byte_next;
      out_frame_end <= (idx == 3'd1) || pair_end;
      out_last      <= cmd_end;
    end
  end

  assign spi.valid     = out_valid;
  assign spi.spi_byte  = out_byte;
  assign spi.frame_end = out_frame_end;
  assign spi.last      = out_last;

endmodule

`default_nettype wire

@@ design/dds_spi_command_framer_core.sv @@
// A request passes the calc pipeline stages and the sequencer command and output registers.
// Throughput: one byte per cycle from the byte sequencer while spi.ready is high, so seven
// bytes for a frequency command, six for amplitude, five for phase and seven per channel for
// the all-channel command; a command to a channel that does not exist makes no bytes.
// Reset clears the pipeline valid bits and the sequencer and loads the register addresses
// with their defaults.
`default_nettype none

module dds_spi_command_framer_core
  import dsf_pkg::*;
#(
  parameter int NUM_CHANNELS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  dsf_cmd_if.sink          cmd,
  dsf_byte_if.source       spi,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [6:0]  cfg_data
);

  dsf_addr_t addr;
  dsf_cmd_t  calc_res;
  logic      calc_valid;
  logic      calc_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      addr.select_addr <= SELECT_ADDR_RESET;
      addr.freq_addr   <= FREQ_ADDR_RESET;
      addr.amp_addr    <= AMP_ADDR_RESET;
      addr.phase_addr  <= PHASE_ADDR_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SELECT: addr.select_addr <= cfg_data;
        CFG_FREQ:   addr.freq_addr   <= cfg_data;
        CFG_AMP:    addr.amp_addr    <= cfg_data;
        CFG_PHASE:  addr.phase_addr  <= cfg_data;
        default:    addr.select_addr <= addr.select_addr;
      endcase
    end
  end

  dsf_calc #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_calc (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .res       (calc_res),
    .res_valid (calc_valid),
    .res_ready (calc_ready)
  );

  dsf_serializer #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_serializer (
    .clk       (clk),
    .rst       (rst),
    .addr      (addr),
    .req       (calc_res),
    .req_valid (calc_valid),
    .req_ready (calc_ready),
    .spi       (spi)
  );

endmodule

`default_nettype wire

@@ sim/dsf_frame_checker.sv @@
// Checker that predicts the serial bytes of every command request and compares them in order.
`default_nettype none

module dsf_frame_checker
  import dsf_pkg::*;
#(
  parameter int NUM_CHANNELS = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  dsf_cmd_if              cmd,
  dsf_byte_if             spi,
  input  wire logic       cfg_wr_en,
  input  wire logic [1:0] cfg_index,
  input  wire logic [6:0] cfg_data,
  output int              errors,
  output int              outstanding,
  output int              bytes_seen,
  output int              commands_seen
);

  typedef struct packed {
    logic [7:0] data;
    logic       frame_end;
    logic       last;
  } framed_byte_t;

  framed_byte_t expected_bytes[$];
  dsf_addr_t    addr_map;
  int           err_count;
  int           byte_count;
  int           cmd_count;

  task automatic report_mismatch(input string msg);
    if (err_count < 40) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
    err_count++;
  endtask

  task automatic push_frame(input logic [6:0] addr, input logic [31:0] value, input int len,
                            input bit final_frame);
    framed_byte_t b;
    b.data = {1'b0, addr};
    b.frame_end = 1'b0;
    b.last = 1'b0;
    expected_bytes.push_back(b);
    for (int i = len - 1; i >= 0; i--) begin
      b.data = value[8*i +: 8];
      b.frame_end = (i == 0);
      b.last = (i == 0) && final_frame;
      expected_bytes.push_back(b);
    end
  endtask

  task automatic predict_frames(input dsf_op_t op, input logic [2:0] ch, input logic [28:0] hz,
                                input logic [15:0] amp, input logic signed [25:0] ph);
    longint unsigned wide;
    logic [31:0]     ftw;
    logic [7:0]      sel;
    longint          deg;
    logic [31:0]     offset;
    wide = {35'd0, hz} << 32;
    ftw = 32'(wide / 64'd500000000);
    if (op == OP_FREQ_ALL) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        sel = SELECT_BASE << c;
        push_frame(addr_map.select_addr, {24'd0, sel}, 1, 1'b0);
        push_frame(addr_map.freq_addr, ftw, 4, c == NUM_CHANNELS - 1);
      end
    end else if (int'(ch) < NUM_CHANNELS) begin
      sel = SELECT_BASE << ch;
      push_frame(addr_map.select_addr, {24'd0, sel}, 1, 1'b0);
      case (op)
        OP_FREQ: begin
          push_frame(addr_map.freq_addr, ftw, 4, 1'b1);
        end
        OP_AMP: begin
          push_frame(addr_map.amp_addr, {16'd0, amp | AMP_ENABLE}, 3, 1'b1);
        end
        default: begin
          deg = longint'(ph);
          if (deg < 0) deg = 0;
          if (deg > longint'(PHASE_FULL)) deg = longint'(PHASE_FULL);
          offset = 32'((longint'(PHASE_FULL) - deg + longint'(PHASE_ROUND)) / 1440);
          push_frame(addr_map.phase_addr, offset, 2, 1'b1);
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    framed_byte_t want;
    if (rst) begin
      addr_map.select_addr = SELECT_ADDR_RESET;
      addr_map.freq_addr = FREQ_ADDR_RESET;
      addr_map.amp_addr = AMP_ADDR_RESET;
      addr_map.phase_addr = PHASE_ADDR_RESET;
      expected_bytes.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_SELECT: addr_map.select_addr = cfg_data;
          CFG_FREQ:   addr_map.freq_addr = cfg_data;
          CFG_AMP:    addr_map.amp_addr = cfg_data;
          default:    addr_map.phase_addr = cfg_data;
        endcase
      end
      if (cmd.valid && cmd.ready) begin
        predict_frames(dsf_op_t'(cmd.op), cmd.channel, cmd.frequency_hz, cmd.amplitude_word,
                       cmd.phase_deg_q16);
        cmd_count++;
      end
      if (spi.valid && spi.ready) begin
        byte_count++;
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("byte %02h arrived with nothing expected", spi.spi_byte));
        end else begin
          want = expected_bytes.pop_front();
          if (spi.spi_byte !== want.data)
            report_mismatch($sformatf("spi_byte %02h, expected %02h", spi.spi_byte, want.data));
          if (spi.frame_end !== want.frame_end)
            report_mismatch($sformatf("frame_end %b, expected %b on byte %02h",
                                      spi.frame_end, want.frame_end, want.data));
          if (spi.last !== want.last)
            report_mismatch($sformatf("last %b, expected %b on byte %02h",
                                      spi.last, want.last, want.data));
        end
      end
    end
    errors <= err_count;
    outstanding <= expected_bytes.size();
    bytes_seen <= byte_count;
    commands_seen <= cmd_count;
  end

endmodule

`default_nettype wire

@@ sim/tb_dds_spi_command_framer_core.sv @@
// Top of the framer testbench: clock, reset, command and register stimulus, and the verdict.
`default_nettype none

module tb_dds_spi_command_framer_core
  import dsf_pkg::*;
;

  localparam int NUM_CHANNELS = 4;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [1:0] cfg_index;
  logic [6:0] cfg_data;
  int         errors;
  int         outstanding;
  int         bytes_seen;
  int         commands_seen;
  int         settings_used;
  bit         src_gaps;
  bit         sink_stalls;

  dsf_cmd_if  cmd();
  dsf_byte_if spi();

  dds_spi_command_framer_core #(.NUM_CHANNELS(NUM_CHANNELS)) uut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd.sink),
    .spi       (spi.source),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dsf_frame_checker #(.NUM_CHANNELS(NUM_CHANNELS)) frame_chk (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .spi           (spi),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .outstanding   (outstanding),
    .bytes_seen    (bytes_seen),
    .commands_seen (commands_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    spi.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_stalls && $urandom_range(0, 5) == 0) begin
        spi.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      spi.ready <= 1'b1;
    end
  end

  function automatic logic [28:0] pick_hz();
    case ($urandom_range(0, 4))
      0:       return 29'($urandom_range(0, 499999999));
      1:       return 29'($urandom);
      2:       return 29'($urandom_range(0, 1000));
      3:       return 29'($urandom_range(499999000, 536870911));
      default: return 29'($urandom_range(0, 499999999));
    endcase
  endfunction

  function automatic logic [15:0] pick_amp();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [25:0] pick_phase();
    int full;
    full = int'(PHASE_FULL);
    case ($urandom_range(0, 5))
      0:       return 26'($urandom_range(0, full));
      1:       return 26'($urandom);
      2:       return 26'(full - 720 - 1440 * $urandom_range(0, 16383));
      3:       return 26'($urandom_range(full, 33554431));
      4:       return 26'($urandom_range(0, 64) - 32);
      default: return 26'($urandom_range(0, full));
    endcase
  endfunction

  task automatic send_request(input dsf_op_t op, input logic [2:0] ch, input logic [28:0] hz,
                              input logic [15:0] amp, input logic signed [25:0] ph);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.op <= op;
    cmd.channel <= ch;
    cmd.frequency_hz <= hz;
    cmd.amplitude_word <= amp;
    cmd.phase_deg_q16 <= ph;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
  endtask

  task automatic drain();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic load_addresses(input logic [6:0] sel, input logic [6:0] fr,
                                input logic [6:0] am, input logic [6:0] ph);
    write_reg(CFG_SELECT, sel);
    write_reg(CFG_FREQ, fr);
    write_reg(CFG_AMP, am);
    write_reg(CFG_PHASE, ph);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  task automatic run_random(input int target);
    int          produced;
    dsf_op_t     op;
    logic [2:0]  ch;
    produced = 0;
    while (produced < target) begin
      op = dsf_op_t'($urandom_range(0, 3));
      ch = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
      send_request(op, ch, pick_hz(), pick_amp(), pick_phase());
      if (op == OP_FREQ_ALL || int'(ch) < NUM_CHANNELS) produced++;
    end
  endtask

  task automatic run_phase(input bit gaps, input bit stalls, input int target);
    src_gaps = gaps;
    sink_stalls = stalls;
    run_random(target / 2);
    drain();
    run_random(target - target / 2);
    drain();
  endtask

  initial begin
    settings_used = 1;
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_SELECT;
    cfg_data <= 7'd0;
    cmd.valid <= 1'b0;
    cmd.op <= OP_FREQ;
    cmd.channel <= 3'd0;
    cmd.frequency_hz <= 29'd0;
    cmd.amplitude_word <= 16'd0;
    cmd.phase_deg_q16 <= 26'sd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(OP_FREQ, 3'd0, 29'd0, 16'd0, 26'sd0);
    send_request(OP_FREQ, 3'd1, 29'd499999999, 16'd0, 26'sd0);
    send_request(OP_FREQ, 3'd2, 29'h1FFFFFFF, 16'd0, 26'sd0);
    send_request(OP_FREQ, 3'd3, 29'd500000000, 16'd0, 26'sd0);
    send_request(OP_FREQ, 3'd2, 29'd1, 16'hFFFF, 26'sd0);
    send_request(OP_AMP, 3'd0, 29'd0, 16'h0000, 26'sd0);
    send_request(OP_AMP, 3'd3, 29'h1FFFFFFF, 16'hFFFF, 26'sd0);
    send_request(OP_AMP, 3'd1, 29'd0, 16'h1000, 26'sd0);
    send_request(OP_PHASE, 3'd0, 29'd0, 16'd0, 26'sd0);
    send_request(OP_PHASE, 3'd1, 29'd0, 16'd0, 26'sd23592960);
    send_request(OP_PHASE, 3'd2, 29'd0, 16'd0, -26'sd1);
    send_request(OP_PHASE, 3'd3, 29'd0, 16'd0, -26'sd33554432);
    send_request(OP_PHASE, 3'd0, 29'd0, 16'd0, 26'sd33554431);
    send_request(OP_PHASE, 3'd1, 29'd0, 16'd0, 26'sd23592240);
    send_request(OP_PHASE, 3'd2, 29'd0, 16'd0, 26'sd23592241);
    send_request(OP_PHASE, 3'd3, 29'd0, 16'd0, 26'sd11796480);
    send_request(OP_FREQ_ALL, 3'd5, 29'd123456789, 16'd0, 26'sd0);
    send_request(OP_FREQ_ALL, 3'd0, 29'h1FFFFFFF, 16'd0, 26'sd0);
    send_request(OP_FREQ, 3'd4, 29'd1000, 16'd0, 26'sd0);
    send_request(OP_AMP, 3'd7, 29'd0, 16'h5A5A, 26'sd0);
    send_request(OP_PHASE, 3'd5, 29'd0, 16'd0, 26'sd65536);
    send_request(OP_FREQ, 3'd3, 29'd250000000, 16'd0, 26'sd0);
    drain();

    load_addresses(7'd0, 7'd0, 7'd0, 7'd0);
    run_phase(1'b1, 1'b1, 36);
    load_addresses(7'd127, 7'd127, 7'd127, 7'd127);
    run_phase(1'b0, 1'b1, 36);
    load_addresses(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                   7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
    run_phase(1'b1, 1'b0, 36);
    load_addresses(7'd127, 7'd0, 7'd127, 7'd0);
    run_phase(1'b1, 1'b1, 36);
    load_addresses(SELECT_ADDR_RESET, FREQ_ADDR_RESET, AMP_ADDR_RESET, PHASE_ADDR_RESET);
    run_phase(1'b0, 1'b0, 36);

    repeat (10) @(posedge clk);
    $display("Run covered %0d command requests and %0d serial bytes", commands_seen, bytes_seen);
    $display("over %0d register address settings, with and without idling.", settings_used);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
